[hdl/spq_pkg.sv]
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int M_TDATA_W    = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

[hdl/spq_cell.sv]
module spq_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_prev_keep,
    input  logic signed [spq_pkg::DATA_W-1:0] i_prev_value,
    input  logic                             i_prev_valid,
    input  logic signed [spq_pkg::DATA_W-1:0] i_next_value,
    input  logic                             i_next_valid,
    output logic                             o_keep,
    output logic signed [spq_pkg::DATA_W-1:0] o_value,
    output logic                             o_valid
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_valid, n_valid;

    // an entry greater or equal to the new value stays ahead of it
    assign o_keep  = r_valid && (r_value >= i_ctl.value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_value = i_ctl.value;
                    n_valid = 1'b1;
                end else begin
                    n_value = i_prev_value;
                    n_valid = i_prev_valid;
                end
            end
        end else if (i_ctl.pop) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

[hdl/sorted_priority_queue.sv]
// result: registered from the accepted input transaction, valid in the cycle after it
// throughput: one transaction per cycle while results are taken; every cell of the
// sorted chain shifts or holds in the same cycle: an insert or pop takes a single step
// the output register frees again in the cycle its result is taken
// reset: synchronous, clears the cell valid bits, the entry count and the output valid
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [spq_pkg::DATA_W-1:0]          i_s_axis_tdata,  // value
    input  logic                                i_s_axis_tuser,  // cmd
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [spq_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,  // out_value, occupancy
    output logic [spq_pkg::STATUS_W-1:0]        o_m_axis_tuser   // status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    t_cell_ctl                  w_ctl;
    t_status                    w_status;
    logic signed [DATA_W-1:0]   w_out_value;

    logic                       w_keep  [CAPACITY];
    logic signed [DATA_W-1:0]   w_value [CAPACITY];
    logic                       w_valid [CAPACITY];

    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W+OCC_W-1:0]     w_count_ext;
    logic                       r_out_valid;
    logic [M_TDATA_W-1:0]       r_out_data;
    t_status                    r_out_status;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CNT_W'(CAPACITY));
    assign w_empty         = (r_count == '0);

    assign w_ctl.ins   = w_accept && !i_s_axis_tuser && !w_full;
    assign w_ctl.pop   = w_accept && i_s_axis_tuser && !w_empty;
    assign w_ctl.value = $signed(i_s_axis_tdata);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                     w_pk;
            logic signed [DATA_W-1:0] w_pv;
            logic                     w_pvld;
            logic signed [DATA_W-1:0] w_nv;
            logic                     w_nvld;

            if (gi == 0) begin : g_head
                assign w_pk   = 1'b1;
                assign w_pv   = w_ctl.value;
                assign w_pvld = 1'b0;
            end else begin : g_body
                assign w_pk   = w_keep[gi-1];
                assign w_pv   = w_value[gi-1];
                assign w_pvld = w_valid[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_nv   = '0;
                assign w_nvld = 1'b0;
            end else begin : g_mid
                assign w_nv   = w_value[gi+1];
                assign w_nvld = w_valid[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev_keep  (w_pk),
                .i_prev_value (w_pv),
                .i_prev_valid (w_pvld),
                .i_next_value (w_nv),
                .i_next_valid (w_nvld),
                .o_keep       (w_keep[gi]),
                .o_value      (w_value[gi]),
                .o_valid      (w_valid[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        w_out_value = '0;
        if (!i_s_axis_tuser) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_status    = ST_POPPED;
                w_out_value = w_value[0];
                n_count     = r_count - 1'b1;
            end
        end
    end

    // occupancy field carries the count masked to its width
    assign w_count_ext = (CNT_W + OCC_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_data   <= {(M_TDATA_W - DATA_W - OCC_W)'(0), w_count_ext[OCC_W-1:0],
                             w_out_value};
            r_out_status <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

[hdl/spq_checker.sv]
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0] i_m_tdata,
    input logic [spq_pkg::STATUS_W-1:0]  i_m_tuser
);
    import spq_pkg::*;

    // a waiting result blocks the next transaction
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |-> !i_s_tready)
        else $error("input accepted while result stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)
                                         && $stable(i_m_tuser)))
        else $error("stalled result changed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser == ST_EMPTY) |-> (i_m_tdata == '0))
        else $error("pop on empty carries data");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser == ST_FULL) |->
            (i_m_tdata[DATA_W-1:0] == '0 && i_m_tdata[DATA_W+OCC_W-1:DATA_W] == OCC_W'(CAPACITY)))
        else $error("dropped insert with wrong occupancy");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);
